FILE: sv/ita2rf_pkg.sv
// ita2rf_pkg: types, codes and the ITA2 lookup table for the RTTY framer.
// Used by ita2rf_decode and ita2_rtty_framer; depends on nothing.
package ita2rf_pkg;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic        level;
		logic [18:0] duration_samples;
		logic        last;
	} out_item_t;

	// one decoded word: an idle mark, or up to three frames
	typedef struct packed {
		logic            is_idle;
		logic [1:0]      nframes;
		logic [2:0][4:0] codes;
	} job_t;

	typedef struct packed {
		logic       figs;
		logic [4:0] code;
	} lookup_t;

	localparam logic [1:0] MODE_CHAR  = 2'd0;
	localparam logic [1:0] MODE_BEGIN = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;

	localparam logic [4:0] CODE_FIGS  = 5'd27;
	localparam logic [4:0] CODE_LTRS  = 5'd31;
	localparam logic [4:0] CODE_CR    = 5'd8;
	localparam logic [4:0] CODE_SPACE = 5'd4;

	localparam logic [7:0] ASCII_LF = 8'd10;
	localparam logic [7:0] ASCII_CR = 8'd13;
	localparam logic [7:0] ASCII_LC_A = 8'd97;
	localparam logic [7:0] ASCII_LC_Z = 8'd122;

	// element index within a frame
	localparam logic [2:0] EL_START = 3'd0;
	localparam logic [2:0] EL_STOP  = 3'd6;

	// letters table first, then figures; anything else goes as a space
	function automatic lookup_t ita2_lookup(input logic [7:0] ch);
		lookup_t r;
		r.figs = 1'b0;
		r.code = CODE_SPACE;
		case (ch)
			8'd69: r.code = 5'd1;   // E
			8'd10: r.code = 5'd2;   // LF
			8'd65: r.code = 5'd3;   // A
			8'd32: r.code = 5'd4;   // space
			8'd83: r.code = 5'd5;   // S
			8'd73: r.code = 5'd6;   // I
			8'd85: r.code = 5'd7;   // U
			8'd13: r.code = 5'd8;   // CR
			8'd68: r.code = 5'd9;   // D
			8'd82: r.code = 5'd10;  // R
			8'd74: r.code = 5'd11;  // J
			8'd78: r.code = 5'd12;  // N
			8'd70: r.code = 5'd13;  // F
			8'd67: r.code = 5'd14;  // C
			8'd75: r.code = 5'd15;  // K
			8'd84: r.code = 5'd16;  // T
			8'd90: r.code = 5'd17;  // Z
			8'd76: r.code = 5'd18;  // L
			8'd87: r.code = 5'd19;  // W
			8'd72: r.code = 5'd20;  // H
			8'd89: r.code = 5'd21;  // Y
			8'd80: r.code = 5'd22;  // P
			8'd81: r.code = 5'd23;  // Q
			8'd79: r.code = 5'd24;  // O
			8'd66: r.code = 5'd25;  // B
			8'd71: r.code = 5'd26;  // G
			8'd77: r.code = 5'd28;  // M
			8'd88: r.code = 5'd29;  // X
			8'd86: r.code = 5'd30;  // V
			8'd51: begin r.figs = 1'b1; r.code = 5'd1;  end // 3
			8'd45: begin r.figs = 1'b1; r.code = 5'd3;  end // -
			8'd39: begin r.figs = 1'b1; r.code = 5'd5;  end // '
			8'd56: begin r.figs = 1'b1; r.code = 5'd6;  end // 8
			8'd55: begin r.figs = 1'b1; r.code = 5'd7;  end // 7
			8'd36: begin r.figs = 1'b1; r.code = 5'd9;  end // $
			8'd52: begin r.figs = 1'b1; r.code = 5'd10; end // 4
			8'd7:  begin r.figs = 1'b1; r.code = 5'd11; end // bell
			8'd44: begin r.figs = 1'b1; r.code = 5'd12; end // ,
			8'd33: begin r.figs = 1'b1; r.code = 5'd13; end // !
			8'd58: begin r.figs = 1'b1; r.code = 5'd14; end // :
			8'd40: begin r.figs = 1'b1; r.code = 5'd15; end // (
			8'd53: begin r.figs = 1'b1; r.code = 5'd16; end // 5
			8'd34: begin r.figs = 1'b1; r.code = 5'd17; end // "
			8'd41: begin r.figs = 1'b1; r.code = 5'd18; end // )
			8'd50: begin r.figs = 1'b1; r.code = 5'd19; end // 2
			8'd35: begin r.figs = 1'b1; r.code = 5'd20; end // #
			8'd54: begin r.figs = 1'b1; r.code = 5'd21; end // 6
			8'd48: begin r.figs = 1'b1; r.code = 5'd22; end // 0
			8'd49: begin r.figs = 1'b1; r.code = 5'd23; end // 1
			8'd57: begin r.figs = 1'b1; r.code = 5'd24; end // 9
			8'd63: begin r.figs = 1'b1; r.code = 5'd25; end // ?
			8'd38: begin r.figs = 1'b1; r.code = 5'd26; end // &
			8'd46: begin r.figs = 1'b1; r.code = 5'd28; end // .
			8'd47: begin r.figs = 1'b1; r.code = 5'd29; end // /
			8'd59: begin r.figs = 1'b1; r.code = 5'd30; end // ;
			default: begin
				r.figs = 1'b0;
				r.code = CODE_SPACE;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: sv/ita2_rtty_framer.sv
// ita2_rtty_framer: ITA2 RTTY line framer, top level.
// Depends on ita2rf_pkg and ita2rf_decode.
//
// Each accepted word (begin message, end message or one ASCII byte) becomes a
// run of line elements, issued one per clock from a registered element
// sequencer: begin and end give one idle mark; a character gives 7, 14
// or 21 elements (optional shift frame, the character frame, and a CR frame
// after LF); an LF straight after a CR gives nothing. The next word is taken
// in the cycle the current one's last element is issued. The sequencer holds
// while the output register carries a stalled element. Length registers
// reading zero act as one sample. Registers sit at APB byte addresses 0, 4
// and 8.
module ita2_rtty_framer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ita2rf_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ita2rf_pkg::out_item_t out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import ita2rf_pkg::*;

	localparam logic [1:0] REG_BIT  = 2'd0;
	localparam logic [1:0] REG_STOP = 2'd1;
	localparam logic [1:0] REG_IDLE = 2'd2;

	logic [14:0] bit_samples_q;
	logic [14:0] stop_samples_q;
	logic [18:0] idle_samples_q;
	logic        cfg_wr;

	logic        figs_shift_q;
	logic        after_cr_q;
	logic        figs_shift_nx;
	logic        after_cr_nx;
	logic        has_job;
	job_t        job_nx;

	logic        job_valid_q;
	job_t        job_q;
	logic [1:0]  frame_q;
	logic [2:0]  el_q;

	logic        out_valid_q;
	out_item_t   out_data_q;

	logic        out_free;
	logic        emit;
	logic        el_last;
	logic        job_done;
	logic        in_acc;
	logic [4:0]  cur_code;
	logic [4:0]  code_shift;
	logic [18:0] bit_len;
	logic [18:0] stop_len;
	logic [18:0] idle_len;
	out_item_t   elem;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_samples_q  <= 15'd176;
			stop_samples_q <= 15'd264;
			idle_samples_q <= 19'd3520;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BIT:  bit_samples_q  <= pwdata[14:0];
				REG_STOP: stop_samples_q <= pwdata[14:0];
				REG_IDLE: idle_samples_q <= pwdata[18:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BIT:  prdata = {17'd0, bit_samples_q};
			REG_STOP: prdata = {17'd0, stop_samples_q};
			REG_IDLE: prdata = {13'd0, idle_samples_q};
			default:  prdata = 32'd0;
		endcase
	end

	ita2rf_decode u_decode (
		.item          (in_data),
		.figs_shift    (figs_shift_q),
		.after_cr      (after_cr_q),
		.has_job       (has_job),
		.job           (job_nx),
		.figs_shift_nx (figs_shift_nx),
		.after_cr_nx   (after_cr_nx)
	);

	// element sequencer
	assign out_free = !out_valid_q || !out_stall;
	assign emit     = job_valid_q && out_free;
	assign el_last  = job_q.is_idle ||
	                  ((el_q == EL_STOP) && (frame_q == job_q.nframes - 2'd1));
	assign job_done = emit && el_last;
	assign in_stall = job_valid_q && !job_done;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		case (frame_q)
			2'd0:    cur_code = job_q.codes[0];
			2'd1:    cur_code = job_q.codes[1];
			2'd2:    cur_code = job_q.codes[2];
			default: cur_code = job_q.codes[2];
		endcase
	end

	assign code_shift = cur_code >> (el_q - 3'd1);
	assign bit_len    = (bit_samples_q == 15'd0) ? 19'd1 : {4'd0, bit_samples_q};
	assign stop_len   = (stop_samples_q == 15'd0) ? 19'd1 : {4'd0, stop_samples_q};
	assign idle_len   = (idle_samples_q == 19'd0) ? 19'd1 : idle_samples_q;

	always_comb begin
		elem.last = el_last;
		if (job_q.is_idle) begin
			elem.level            = 1'b1;
			elem.duration_samples = idle_len;
		end else begin
			case (el_q)
				EL_START: begin
					elem.level            = 1'b0;
					elem.duration_samples = bit_len;
				end
				3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
					elem.level            = code_shift[0];
					elem.duration_samples = bit_len;
				end
				default: begin
					elem.level            = 1'b1;
					elem.duration_samples = stop_len;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			figs_shift_q <= 1'b0;
			after_cr_q   <= 1'b0;
			job_valid_q  <= 1'b0;
			frame_q      <= 2'd0;
			el_q         <= EL_START;
		end else begin
			if (in_acc) begin
				figs_shift_q <= figs_shift_nx;
				after_cr_q   <= after_cr_nx;
			end
			if (in_acc && has_job) begin
				job_valid_q <= 1'b1;
				frame_q     <= 2'd0;
				el_q        <= EL_START;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
			end else if (emit) begin
				if (el_q == EL_STOP) begin
					el_q    <= EL_START;
					frame_q <= frame_q + 2'd1;
				end else begin
					el_q <= el_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_job)
			job_q <= job_nx;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_data_q <= elem;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/ita2rf_decode.sv
// ita2rf_decode: folds one input word and the shift/CR state into a frame job.
// Depends on ita2rf_pkg.
module ita2rf_decode (
	input  ita2rf_pkg::in_item_t item,
	input  logic                 figs_shift,
	input  logic                 after_cr,
	output logic                 has_job,
	output ita2rf_pkg::job_t     job,
	output logic                 figs_shift_nx,
	output logic                 after_cr_nx
);
	import ita2rf_pkg::*;

	logic [7:0] folded;
	logic [7:0] upper;
	logic       swallow;
	logic       is_lf;
	lookup_t    lk;

	assign folded  = (item.char_code == ASCII_CR) ? ASCII_LF : item.char_code;
	assign upper   = (folded >= ASCII_LC_A && folded <= ASCII_LC_Z) ?
	                 folded - 8'd32 : folded;
	assign lk      = ita2_lookup(upper);
	assign is_lf   = (upper == ASCII_LF);
	assign swallow = (item.char_code == ASCII_LF) && after_cr;

	always_comb begin
		has_job       = 1'b0;
		job           = '0;
		figs_shift_nx = figs_shift;
		after_cr_nx   = after_cr;
		case (item.mode)
			MODE_BEGIN: begin
				has_job       = 1'b1;
				job.is_idle   = 1'b1;
				job.nframes   = 2'd1;
				figs_shift_nx = 1'b0;
				after_cr_nx   = 1'b0;
			end
			MODE_END: begin
				has_job     = 1'b1;
				job.is_idle = 1'b1;
				job.nframes = 2'd1;
			end
			MODE_CHAR: begin
				after_cr_nx = (item.char_code == ASCII_CR);
				if (!swallow) begin
					has_job = 1'b1;
					figs_shift_nx = lk.figs;
					if (lk.figs != figs_shift) begin
						job.codes[0] = lk.figs ? CODE_FIGS : CODE_LTRS;
						job.codes[1] = lk.code;
						job.codes[2] = CODE_CR;
						job.nframes  = is_lf ? 2'd3 : 2'd2;
					end else begin
						job.codes[0] = lk.code;
						job.codes[1] = CODE_CR;
						job.nframes  = is_lf ? 2'd2 : 2'd1;
					end
				end
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

endmodule
